/* src/pmg_pkg.sv */
// Shared types, constants and helpers for the PS/2 packet gesture block.
package pmg_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DeltaW = 9;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned SumW   = 18;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Mouse acknowledge code, never a valid header
  localparam logic [ByteW-1:0] AckCode = 8'hFA;

  // Header bit positions
  localparam int unsigned HdrLeft   = 0;
  localparam int unsigned HdrRight  = 1;
  localparam int unsigned HdrMiddle = 2;
  localparam int unsigned HdrSync   = 3;
  localparam int unsigned HdrXSign  = 4;
  localparam int unsigned HdrYSign  = 5;
  localparam int unsigned HdrXOvf   = 6;
  localparam int unsigned HdrYOvf   = 7;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_LENGTH  = 8'd0,
    CFG_SIDE_TOLERANCE = 8'd1
  } cfg_idx_e;

  // Packet byte position
  typedef enum logic [1:0] {
    POS_HDR = 2'd0,
    POS_X   = 2'd1,
    POS_Y   = 2'd2
  } pos_e;

  // Gesture phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DRAW = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  // One assembled packet
  typedef struct packed {
    logic [ByteW-1:0] header;
    logic [ByteW-1:0] x_byte;
    logic [ByteW-1:0] y_byte;
  } packet_t;

  // Magnitude of a running sum
  function automatic logic [SumW-1:0] sum_mag(logic signed [SumW-1:0] v);
    logic [SumW-1:0] r;
    r = v[SumW-1] ? SumW'(-v) : SumW'(v);
    return r;
  endfunction

  // Magnitude of the target length
  function automatic logic [CfgW:0] len_mag(logic signed [CfgW-1:0] v);
    logic signed [CfgW:0] w;
    w = {v[CfgW-1], v};
    return w[CfgW] ? (CfgW+1)'(-w) : (CfgW+1)'(w);
  endfunction

endpackage

/* src/pmg_if.sv */
// Channel interfaces: mouse bytes in, decoded packets out, register writes.
interface pmg_byte_if;
  logic                     valid;
  logic                     ready;
  logic [pmg_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pmg_res_if;
  logic                             valid;
  logic                             ready;
  logic                             left_pressed;
  logic                             right_pressed;
  logic                             middle_pressed;
  logic                             x_overflow;
  logic                             y_overflow;
  logic signed [pmg_pkg::DeltaW-1:0] delta_x;
  logic signed [pmg_pkg::DeltaW-1:0] delta_y;
  logic                             gesture_done;

  modport source (output valid, output left_pressed, output right_pressed,
                  output middle_pressed, output x_overflow, output y_overflow,
                  output delta_x, output delta_y, output gesture_done, input ready);
  modport sink   (input valid, input left_pressed, input right_pressed,
                  input middle_pressed, input x_overflow, input y_overflow,
                  input delta_x, input delta_y, input gesture_done, output ready);
endinterface

interface pmg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pmg_pkg::CfgIdxW-1:0] index;
  logic [pmg_pkg::CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/pmg_front.sv */
// Front end: header sync and three-byte packet assembly.
module pmg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  pmg_byte_if.sink          rx_i,
  output logic              push_o,
  output pmg_pkg::packet_t  push_pkt_o,
  input  logic              push_ready_i
);
  import pmg_pkg::*;

  pos_e             pos_q, pos_d;
  logic [ByteW-1:0] hdr_q, hdr_d;
  logic [ByteW-1:0] x_q, x_d;
  logic             accept;
  logic             hdr_ok;

  assign accept = rx_i.valid && rx_i.ready;
  assign hdr_ok = rx_i.rx_byte[HdrSync] && (rx_i.rx_byte != AckCode);

  // Next byte position
  always_comb begin
    pos_d = pos_q;
    unique case (pos_q)
      POS_HDR: if (accept && hdr_ok) pos_d = POS_X;
      POS_X:   if (accept) pos_d = POS_Y;
      POS_Y:   if (accept) pos_d = POS_HDR;
      default: pos_d = POS_HDR;
    endcase
  end

  // Outputs: capture bytes, push on the last one
  always_comb begin
    rx_i.ready = (pos_q != POS_Y) || push_ready_i;
    push_o     = accept && (pos_q == POS_Y);
    hdr_d      = hdr_q;
    x_d        = x_q;
    if (accept && (pos_q == POS_HDR) && hdr_ok) hdr_d = rx_i.rx_byte;
    if (accept && (pos_q == POS_X)) x_d = rx_i.rx_byte;
    push_pkt_o = '{header: hdr_q, x_byte: x_q, y_byte: rx_i.rx_byte};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_HDR;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Byte holding registers
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    x_q   <= x_d;
  end

endmodule

/* src/pmg_queue.sv */
// Short packet queue between front and back.
module pmg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pmg_pkg::packet_t  push_pkt_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output pmg_pkg::packet_t  pop_pkt_o,
  input  logic              pop_i
);
  import pmg_pkg::*;

  packet_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != QCntW'(QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_pkt_o    = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop)  rd_d = (rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_pkt_i;
  end

endmodule

/* src/pmg_back.sv */
// Back end: packet decode, gesture machine, config registers, result register.
module pmg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  input  pmg_pkg::packet_t  pop_pkt_i,
  output logic              pop_o,
  pmg_cfg_if.sink           cfg_i,
  pmg_res_if.source         res_o
);
  import pmg_pkg::*;

  logic signed [CfgW-1:0]   len_q, len_d;
  logic [CfgW-1:0]          tol_q, tol_d;
  phase_e                   phase_q, phase_d, phase_evt;
  logic signed [SumW-1:0]   vsum_q, vsum_d;
  logic signed [SumW-1:0]   hsum_q, hsum_d;
  logic                     out_vld_q, out_vld_d;
  logic                     reach;
  logic                     move;
  logic                     same;
  logic signed [DeltaW-1:0] dx, dy;
  logic                     right;
  logic signed [SumW-1:0]   vbase, hbase, vnew, hnew;

  // Config writes
  assign cfg_i.ready = 1'b1;
  always_comb begin
    len_d = len_q;
    tol_d = tol_q;
    if (cfg_i.valid && (cfg_i.index == CFG_TARGET_LENGTH))  len_d = cfg_i.data;
    if (cfg_i.valid && (cfg_i.index == CFG_SIDE_TOLERANCE)) tol_d = cfg_i.data;
  end

  // Decode
  assign pop_o = pop_valid_i && (!out_vld_q || res_o.ready);
  assign right = pop_pkt_i.header[HdrRight];
  assign dx    = {pop_pkt_i.header[HdrXSign], pop_pkt_i.x_byte};
  assign dy    = {pop_pkt_i.header[HdrYSign], pop_pkt_i.y_byte};

  // Button event
  always_comb begin
    phase_evt = phase_q;
    unique case (phase_q)
      PH_DRAW: if (!right) phase_evt = PH_IDLE;
      PH_DONE: phase_evt = PH_DONE;
      default: phase_evt = right ? PH_DRAW : PH_IDLE;
    endcase
  end

  // Movement sums
  always_comb begin
    move  = ((dx != '0) || (dy != '0)) && (phase_evt == PH_DRAW);
    same  = (!len_q[CfgW-1] && !dy[DeltaW-1]) ||
            ((len_q[CfgW-1] || (len_q == '0)) && (dy[DeltaW-1] || (dy == '0)));
    vbase = (phase_q == PH_DRAW && !right) ? '0 : vsum_q;
    hbase = (phase_q == PH_DRAW && !right) ? '0 : hsum_q;
    vnew  = same ? vbase + SumW'(dy) : '0;
    hnew  = hbase + SumW'(dx);
    if (sum_mag(hnew) >= SumW'(tol_q)) begin
      vnew = '0;
      hnew = '0;
    end
    reach = sum_mag(vnew) >= SumW'(len_mag(len_q));
    vsum_d = vsum_q;
    hsum_d = hsum_q;
    if (pop_o) begin
      vsum_d = move ? vnew : vbase;
      hsum_d = move ? hnew : hbase;
    end
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (pop_o) phase_d = (move && reach) ? PH_DONE : phase_evt;
  end

  // Result register handshake
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_o.ready) out_vld_d = 1'b0;
    if (pop_o)       out_vld_d = 1'b1;
  end
  assign res_o.valid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      tol_q     <= '0;
      phase_q   <= PH_IDLE;
      vsum_q    <= '0;
      hsum_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      tol_q     <= tol_d;
      phase_q   <= phase_d;
      vsum_q    <= vsum_d;
      hsum_q    <= hsum_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_o.left_pressed   <= pop_pkt_i.header[HdrLeft];
      res_o.right_pressed  <= pop_pkt_i.header[HdrRight];
      res_o.middle_pressed <= pop_pkt_i.header[HdrMiddle];
      res_o.x_overflow     <= pop_pkt_i.header[HdrXOvf];
      res_o.y_overflow     <= pop_pkt_i.header[HdrYOvf];
      res_o.delta_x        <= dx;
      res_o.delta_y        <= dy;
      res_o.gesture_done   <= (phase_d == PH_DONE);
    end
  end

endmodule

/* src/ps2_mouse_packet_gesture.sv */
// PS/2 three-byte packet decoder with right-button vertical line gesture.
// Accepts one mouse byte per cycle while the queue has room; a packet enters the queue
// when its third byte is taken, and the back end then moves it to the output register.
// Sustained rate is one byte per cycle when the output is not stalled, set by the front
// assembler and the gesture update in the back end; the two-entry queue absorbs stalls.
// Reset clears packet position, gesture phase, sums and both config registers.
module ps2_mouse_packet_gesture (
  input  logic      clk_i,
  input  logic      rst_ni,
  pmg_byte_if.sink  rx_i,
  pmg_cfg_if.sink   cfg_i,
  pmg_res_if.source res_o
);
  import pmg_pkg::*;

  logic    push, push_ready, pop_valid, pop;
  packet_t push_pkt, pop_pkt;

  pmg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .push_o      (push),
    .push_pkt_o  (push_pkt),
    .push_ready_i(push_ready)
  );

  pmg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_pkt_i  (push_pkt),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_pkt_o   (pop_pkt),
    .pop_i       (pop)
  );

  pmg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_pkt_i  (pop_pkt),
    .pop_o      (pop),
    .cfg_i      (cfg_i),
    .res_o      (res_o)
  );

endmodule

/* sim/tb_ps2_mouse_packet_gesture.sv */
// Self-checking testbench for the PS/2 packet decoder and its line gesture tracker.
module tb_ps2_mouse_packet_gesture;
  import pmg_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  // One decoded packet as the block reports it
  typedef struct packed {
    logic       left;
    logic       right;
    logic       middle;
    logic       x_ovf;
    logic       y_ovf;
    logic [8:0] dx;
    logic [8:0] dy;
    logic       done;
  } mouse_report_t;

  logic clk_i;
  logic rst_ni;

  pmg_byte_if byte_ch ();
  pmg_cfg_if  cfg_ch ();
  pmg_res_if  pkt_ch ();

  ps2_mouse_packet_gesture dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (byte_ch),
    .cfg_i  (cfg_ch),
    .res_o  (pkt_ch)
  );

  // Stimulus and scoreboard storage
  logic [7:0]    byte_backlog[$];
  mouse_report_t predicted_reports[$];
  mouse_report_t head_report;
  int            queued_total = 0;
  int            mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;

  // Predictor copy of the configuration and the decoder/gesture state
  logic signed [15:0] length_cfg = '0;
  logic [15:0]        tolerance_cfg = '0;
  pos_e               byte_pos = POS_HDR;
  logic [7:0]         header_q = '0;
  logic [7:0]         x_byte_q = '0;
  phase_e             phase_q = PH_IDLE;
  int                 vert_sum = 0;
  int                 horiz_sum = 0;

  // Clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int magnitude_of(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Advance the decoder by one accepted byte; queue a report when a packet completes
  function automatic void decode_mouse_byte(logic [7:0] b);
    mouse_report_t rpt;
    logic signed [8:0] dx9;
    logic signed [8:0] dy9;
    int dx;
    int dy;
    int len;
    int tol;
    logic same_dir;
    case (byte_pos)
      POS_HDR: begin
        if (b[HdrSync] && b != AckCode) begin
          header_q = b;
          byte_pos = POS_X;
        end
      end
      POS_X: begin
        x_byte_q = b;
        byte_pos = POS_Y;
      end
      default: begin
        byte_pos = POS_HDR;
        dx9 = {header_q[HdrXSign], x_byte_q};
        dy9 = {header_q[HdrYSign], b};
        dx = dx9;
        dy = dy9;
        // right button press/release
        if (phase_q == PH_DRAW) begin
          if (!header_q[HdrRight]) begin
            phase_q = PH_IDLE;
            vert_sum = 0;
            horiz_sum = 0;
          end
        end else if (phase_q != PH_DONE && header_q[HdrRight]) begin
          phase_q = PH_DRAW;
        end
        // movement only counts while drawing
        if ((dx != 0 || dy != 0) && phase_q == PH_DRAW) begin
          len = length_cfg;
          tol = int'(tolerance_cfg);
          same_dir = (len >= 0 && dy >= 0) || (len <= 0 && dy <= 0);
          vert_sum = same_dir ? vert_sum + dy : 0;
          horiz_sum = horiz_sum + dx;
          if (magnitude_of(horiz_sum) >= tol) begin
            vert_sum = 0;
            horiz_sum = 0;
          end
          if (magnitude_of(vert_sum) >= magnitude_of(len)) phase_q = PH_DONE;
        end
        rpt.left   = header_q[HdrLeft];
        rpt.right  = header_q[HdrRight];
        rpt.middle = header_q[HdrMiddle];
        rpt.x_ovf  = header_q[HdrXOvf];
        rpt.y_ovf  = header_q[HdrYOvf];
        rpt.dx     = dx9;
        rpt.dy     = dy9;
        rpt.done   = (phase_q == PH_DONE);
        predicted_reports.push_back(rpt);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string field, logic [8:0] got, logic [8:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", field, got, want));
  endtask

  // Byte driver: holds an item until taken, then offers the next one or idles
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      byte_ch.valid   <= 1'b0;
      byte_ch.rx_byte <= '0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) decode_mouse_byte(byte_ch.rx_byte);
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          byte_ch.valid   <= 1'b1;
          byte_ch.rx_byte <= byte_backlog.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pkt_ch.ready <= 1'b0;
    end else begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        if (predicted_reports.size() == 0) begin
          report_mismatch("report with no packet pending");
        end else begin
          head_report = predicted_reports.pop_front();
          check_field("left_pressed", pkt_ch.left_pressed, head_report.left);
          check_field("right_pressed", pkt_ch.right_pressed, head_report.right);
          check_field("middle_pressed", pkt_ch.middle_pressed, head_report.middle);
          check_field("x_overflow", pkt_ch.x_overflow, head_report.x_ovf);
          check_field("y_overflow", pkt_ch.y_overflow, head_report.y_ovf);
          check_field("delta_x", pkt_ch.delta_x, head_report.dx);
          check_field("delta_y", pkt_ch.delta_y, head_report.dy);
          check_field("gesture_done", pkt_ch.gesture_done, head_report.done);
        end
      end
      pkt_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Register write; the block is idle whenever this is called
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_TARGET_LENGTH) length_cfg = val;
    else tolerance_cfg = val;
  endtask

  // Wait until every byte is taken and every report checked, then let the pipe settle
  task automatic wait_drained();
    while (byte_backlog.size() != 0 || byte_ch.valid || predicted_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_byte(logic [7:0] b);
    byte_backlog.push_back(b);
    queued_total++;
  endtask

  // Well-formed packet: sync bit and sign bits follow the deltas
  task automatic queue_packet(logic [7:0] buttons, int dx, int dy);
    logic [7:0] hdr;
    hdr = buttons;
    hdr[HdrSync]  = 1'b1;
    hdr[HdrXSign] = (dx < 0);
    hdr[HdrYSign] = (dy < 0);
    push_byte(hdr);
    push_byte(8'(dx));
    push_byte(8'(dy));
  endtask

  function automatic logic [7:0] random_buttons(logic right_btn);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    b[HdrRight] = right_btn;
    return b;
  endfunction

  // Mostly small moves, sometimes none, sometimes the full range
  function automatic int random_delta(int span);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return int'($urandom_range(0, 511)) - 256;
    if (r == 1) return 0;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic queue_noise();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: b = AckCode;
      1: begin
        b = 8'($urandom_range(0, 255));
        b[HdrSync] = 1'b0;
      end
      default: b = 8'($urandom_range(0, 255));
    endcase
    push_byte(b);
  endtask

  // Press, a run of moves mostly toward the target, then release
  task automatic queue_stroke();
    int moves;
    int dir;
    int dy;
    moves = $urandom_range(1, 16);
    if (length_cfg > 0) dir = 1;
    else if (length_cfg < 0) dir = -1;
    else dir = $urandom_range(0, 1) ? 1 : -1;
    queue_packet(random_buttons(1'b1), random_delta(8), random_delta(8));
    repeat (moves) begin
      dy = $urandom_range(0, 60);
      if ($urandom_range(0, 9) < 2) dy = random_delta(60);
      else dy = dir * dy;
      queue_packet(random_buttons(1'b1), random_delta(20), dy);
      if ($urandom_range(0, 19) == 0) queue_noise();
    end
    queue_packet(random_buttons(1'b0), random_delta(8), random_delta(8));
  endtask

  task automatic fill_random(int goal);
    int r;
    while (queued_total < goal) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        queue_stroke();
      end else if (r < 90) begin
        push_byte(8'($urandom_range(0, 255)) | 8'h08);
        push_byte(8'($urandom_range(0, 255)));
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        queue_noise();
      end
    end
  endtask

  // Random phase with a full pause for all reports half way through
  task automatic run_phase(int n_bytes);
    fill_random(queued_total + n_bytes / 2);
    wait_drained();
    fill_random(queued_total + n_bytes - n_bytes / 2);
    wait_drained();
  endtask

  function automatic logic [15:0] signed_length(int lo, int hi);
    int v;
    v = $urandom_range(lo, hi);
    return 16'($urandom_range(0, 1) ? v : -v);
  endfunction

  // Test sequence
  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    pkt_ch.ready    = 1'b0;
    rst_ni          = 1'b0;
    send_idle_pct   = 25;
    recv_stall_pct  = 76;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // most negative length, zero tolerance: every move clears the sums
    write_reg(CFG_TARGET_LENGTH, 16'h8000);
    write_reg(CFG_SIDE_TOLERANCE, 16'h0000);

    // headers without sync bit or equal to the ACK code are dropped
    push_byte(8'h00);
    push_byte(AckCode);
    push_byte(8'hF7);
    push_byte(8'h08); push_byte(8'h00); push_byte(8'h00);
    // all header bits set: press, both deltas -1, overflow flags
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
    // press while drawing, most negative deltas
    push_byte(8'h3A); push_byte(8'h00); push_byte(8'h00);
    // dy against the target direction, largest positive deltas
    push_byte(8'h0A); push_byte(8'hFF); push_byte(8'hFF);
    // release with movement that is ignored
    push_byte(8'h08); push_byte(8'h01); push_byte(8'h01);
    // ACK code in the X position is plain data
    push_byte(8'h0D); push_byte(AckCode); push_byte(8'h00);
    // press without movement
    push_byte(8'h0E); push_byte(8'h00); push_byte(8'h00);
    wait_drained();

    // largest length and tolerance
    write_reg(CFG_TARGET_LENGTH, 16'h7FFF);
    write_reg(CFG_SIDE_TOLERANCE, 16'hFFFF);
    run_phase(440);

    send_idle_pct  = 76;
    recv_stall_pct = 25;
    write_reg(CFG_TARGET_LENGTH, signed_length(20000, 32767));
    write_reg(CFG_SIDE_TOLERANCE, 16'($urandom_range(0, 65535)));
    run_phase(440);

    // moderate settings where the gesture can complete
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CFG_TARGET_LENGTH, signed_length(300, 1500));
    write_reg(CFG_SIDE_TOLERANCE, 16'($urandom_range(40, 800)));
    run_phase(440);

    // zero length: first move while drawing completes
    write_reg(CFG_TARGET_LENGTH, 16'h0000);
    write_reg(CFG_SIDE_TOLERANCE, 16'($urandom_range(0, 65535)));
    run_phase(440);

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/pmg_pkg.sv
src/pmg_if.sv
src/pmg_front.sv
src/pmg_queue.sv
src/pmg_back.sv
src/ps2_mouse_packet_gesture.sv
sim/tb_ps2_mouse_packet_gesture.sv
